[rtl/core/quantized_matmul_zero_point_macros.svh]
// Assertion macros for the quantized matrix product block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef QUANTIZED_MATMUL_ZERO_POINT_MACROS_SVH
`define QUANTIZED_MATMUL_ZERO_POINT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define QMZP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define QMZP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/qmzp_pkg.sv]
// Shared types, widths, codes and helpers for the quantized matrix product block.
// No dependencies; every other RTL file but the macro header imports this package.
package qmzp_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int ELEM_BITS   = 8;

    localparam int DIM_W      = 7;
    localparam int IDX_W      = 6;
    localparam int ELEM_W     = 8;
    localparam int ACC_W      = 32;
    localparam int MULT_W     = 31;
    localparam int SHIFT_W    = 6;
    localparam int ZP_W       = 8;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int SUM_W      = DIM_W + ELEM_W;
    localparam int PROD_W     = 64;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [PROD_W-1:0] ELEM_MAX = PROD_W'((65'd1 << ELEM_BITS) - 65'd1);

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_A    = 2'd0,
        ACT_WR_B    = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OP_WR_A = 2'd0,
        OP_WR_B = 2'd1,
        OP_COMP = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_M     = 3'd0,
        CFG_COLS_N     = 3'd1,
        CFG_DEPTH_K    = 3'd2,
        CFG_ZP_A       = 3'd3,
        CFG_ZP_B       = 3'd4,
        CFG_MULT       = 3'd5,
        CFG_SHIFT      = 3'd6,
        CFG_OUT_ZP     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   rows_m;
        logic [DIM_W-1:0]   cols_n;
        logic [DIM_W-1:0]   depth_k;
        logic [ZP_W-1:0]    zp_a;
        logic [ZP_W-1:0]    zp_b;
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
        logic [ZP_W-1:0]    out_zp;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] val;
    } t_cmd;

    // Clamp a dimension register to [1, max_dim].
    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v,
                                                 input int max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/core/qmzp_if.sv]
// Channel interfaces for the quantized matrix product block: input items,
// result items and configuration writes. Depends on qmzp_pkg.
interface qmzp_in_if import qmzp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [ELEM_W-1:0] elem_value;

    modport source (output valid, action, row_index, col_index, elem_value, input ready);
    modport sink   (input valid, action, row_index, col_index, elem_value, output ready);
endinterface

interface qmzp_out_if import qmzp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic signed [ACC_W-1:0] accumulator;
    logic [ELEM_W-1:0] quantized_out;

    modport source (output valid, out_row, out_col, accumulator, quantized_out, input ready);
    modport sink   (input valid, out_row, out_col, accumulator, quantized_out, output ready);
endinterface

interface qmzp_cfg_if import qmzp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/quantized_matmul_zero_point.sv]
// Top level of the quantized matrix product block: configuration registers,
// front end, command queue and back end. Depends on qmzp_pkg and qmzp_if.
//
// Usage:
//   i_in  : input transactions. Action write A / write B stores one element at
//           (row, col); action compute names output cell (m, n). Writes with an
//           index past MAX_DIM, computes outside rows_m x cols_n and the unused
//           action are accepted and dropped without a result.
//   o_out : one result per compute: cell, corrected 32-bit sum, requantized value.
//   i_cfg : register writes by index, always ready; write only while idle.
// Flow: a compute leaves the queue once the back end is idle, then walks the
//   back end (K reads of the two store read ports, one drain, three correction
//   stages, three requantization stages); its result is loaded once the result
//   register is free. A new compute starts only after the last one is loaded;
//   element writes are taken at one per cycle while the back end is idle.
// The command queue holds four transactions, so the input keeps flowing while
//   the back end walks a cell or a finished result waits on a stalled receiver;
//   once the queue is full, i_in.ready drops until the back end pops again.
// Reset restores the register defaults and empties queue and pipeline; the
//   stores keep their contents and must be written before they are read.
module quantized_matmul_zero_point import qmzp_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qmzp_in_if.sink     i_in,
    qmzp_out_if.source  o_out,
    qmzp_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_m  <= DIM_W'(1);
            r_cfg.cols_n  <= DIM_W'(1);
            r_cfg.depth_k <= DIM_W'(1);
            r_cfg.zp_a    <= '0;
            r_cfg.zp_b    <= '0;
            r_cfg.mult    <= MULT_W'(1) << 30;
            r_cfg.shift   <= SHIFT_W'(31);
            r_cfg.out_zp  <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ROWS_M:  r_cfg.rows_m  <= i_cfg.data[DIM_W-1:0];
                CFG_COLS_N:  r_cfg.cols_n  <= i_cfg.data[DIM_W-1:0];
                CFG_DEPTH_K: r_cfg.depth_k <= i_cfg.data[DIM_W-1:0];
                CFG_ZP_A:    r_cfg.zp_a    <= i_cfg.data[ZP_W-1:0];
                CFG_ZP_B:    r_cfg.zp_b    <= i_cfg.data[ZP_W-1:0];
                CFG_MULT:    r_cfg.mult    <= i_cfg.data[MULT_W-1:0];
                CFG_SHIFT:   r_cfg.shift   <= i_cfg.data[SHIFT_W-1:0];
                CFG_OUT_ZP:  r_cfg.out_zp  <= i_cfg.data[ZP_W-1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    qmzp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    qmzp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    qmzp_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

[rtl/core/qmzp_front.sv]
// Front end: accepts input transactions, drops the ones that do nothing and
// turns the rest into queue commands. Depends on qmzp_pkg and qmzp_if.
module qmzp_front import qmzp_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    qmzp_in_if.sink i_in,
    input  t_cfg    i_cfg,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic             w_accept;
    logic             w_wr_ok;
    logic             w_cell_ok;
    logic [DIM_W-1:0] w_m_lim;
    logic [DIM_W-1:0] w_n_lim;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    assign w_m_lim   = dim_eff(i_cfg.rows_m, MAX_DIM);
    assign w_n_lim   = dim_eff(i_cfg.cols_n, MAX_DIM);
    assign w_wr_ok   = (int'(i_in.row_index) < MAX_DIM) && (int'(i_in.col_index) < MAX_DIM);
    assign w_cell_ok = (DIM_W'(i_in.row_index) < w_m_lim) && (DIM_W'(i_in.col_index) < w_n_lim);

    always_comb begin
        o_cmd.row = i_in.row_index;
        o_cmd.col = i_in.col_index;
        o_cmd.val = i_in.elem_value;
        o_cmd.op  = OP_COMP;
        o_push    = 1'b0;
        case (t_action'(i_in.action))
            ACT_WR_A: begin
                o_cmd.op = OP_WR_A;
                o_push   = w_accept && w_wr_ok;
            end
            ACT_WR_B: begin
                o_cmd.op = OP_WR_B;
                o_push   = w_accept && w_wr_ok;
            end
            ACT_COMPUTE: begin
                o_cmd.op = OP_COMP;
                o_push   = w_accept && w_cell_ok;
            end
            // unused action: accept and drop
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/qmzp_queue.sv]
// Short command queue between front and back end.
// Depends on qmzp_pkg.
module qmzp_queue import qmzp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_buf[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/core/qmzp_back.sv]
// Back end: element stores, the K-step walk over one A row and one B column,
// zero-point correction, requantization and the result register.
// Depends on qmzp_pkg, qmzp_if and the assertion macro header.
`include "quantized_matmul_zero_point_macros.svh"

module qmzp_back import qmzp_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    qmzp_out_if.source o_out
);

    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_CORR1 = 9'b000001000,
        S_CORR2 = 9'b000010000,
        S_CORR3 = 9'b000100000,
        S_REQ1  = 9'b001000000,
        S_REQ2  = 9'b010000000,
        S_REQ3  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [ELEM_W-1:0] r_a_mem [MEM_DEPTH];
    logic [ELEM_W-1:0] r_b_mem [MEM_DEPTH];
    logic [ELEM_W-1:0] r_a_q;
    logic [ELEM_W-1:0] r_b_q;

    logic [DIM_W-1:0]  r_k;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [ACC_W-1:0]  r_dot;
    logic [SUM_W-1:0]  r_rsum;
    logic [SUM_W-1:0]  r_csum;
    logic [ZP_W+SUM_W-1:0]    r_p1;
    logic [ZP_W+SUM_W-1:0]    r_p2;
    logic [2*ZP_W-1:0]        r_p3;
    logic [2*ZP_W+DIM_W-1:0]  r_p3k;
    logic [ACC_W-1:0]         r_part;
    logic [ACC_W-1:0]         r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_shr;

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_row;
    logic [IDX_W-1:0]  r_out_col;
    logic [ACC_W-1:0]  r_out_acc;
    logic [ELEM_W-1:0] r_out_q;

    logic              w_we_a;
    logic              w_we_b;
    logic              w_start;
    logic              w_rd;
    logic              w_last_k;
    logic              w_load;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_a_raddr;
    logic [AW-1:0]     w_b_raddr;
    logic [DIM_W-1:0]  w_k_lim;
    logic [2*ELEM_W-1:0] w_ab;
    logic [ZP_W+SUM_W-1:0]    w_p1;
    logic [ZP_W+SUM_W-1:0]    w_p2;
    logic [2*ZP_W-1:0]        w_p3;
    logic [2*ZP_W+DIM_W-1:0]  w_p3k;
    logic signed [ACC_W-1:0]  w_acc_s;
    logic signed [ACC_W-1:0]  w_mult_s;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_round;
    logic signed [PROD_W-1:0] w_shr;
    logic signed [PROD_W-1:0] w_sum;
    logic [ELEM_W-1:0]        w_q;

    assign w_k_lim  = dim_eff(i_cfg.depth_k, MAX_DIM);
    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign w_we_a   = o_pop && (i_cmd.op == OP_WR_A);
    assign w_we_b   = o_pop && (i_cmd.op == OP_WR_B);
    assign w_start  = o_pop && (i_cmd.op == OP_COMP);
    assign w_rd     = (r_state == S_READ);
    assign w_last_k = (r_k == w_k_lim - DIM_W'(1));
    assign w_load   = (r_state == S_REQ3) && (!r_out_vld || o_out.ready);

    assign w_waddr   = AW'(int'(i_cmd.row) * MAX_DIM + int'(i_cmd.col));
    assign w_a_raddr = AW'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_b_raddr = AW'(int'(r_k) * MAX_DIM + int'(r_col));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_start) n_state = S_READ;
            S_READ:  if (w_last_k) n_state = S_DRAIN;
            S_DRAIN: n_state = S_CORR1;
            S_CORR1: n_state = S_CORR2;
            S_CORR2: n_state = S_CORR3;
            S_CORR3: n_state = S_REQ1;
            S_REQ1:  n_state = S_REQ2;
            S_REQ2:  n_state = S_REQ3;
            // hold until the result register is free
            S_REQ3:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd;
            if (w_start) begin
                r_k <= '0;
            end else if (w_rd) begin
                r_k <= r_k + DIM_W'(1);
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Element stores: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_a_mem[w_waddr] <= i_cmd.val;
        end
        if (w_rd) begin
            r_a_q <= r_a_mem[w_a_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_b_mem[w_waddr] <= i_cmd.val;
        end
        if (w_rd) begin
            r_b_q <= r_b_mem[w_b_raddr];
        end
    end

    assign w_ab     = r_a_q * r_b_q;
    assign w_p1     = i_cfg.zp_b * r_rsum;
    assign w_p2     = i_cfg.zp_a * r_csum;
    assign w_p3     = i_cfg.zp_a * i_cfg.zp_b;
    assign w_p3k    = r_p3 * w_k_lim;
    assign w_acc_s  = r_acc;
    assign w_mult_s = {1'b0, i_cfg.mult};
    assign w_prod   = w_acc_s * w_mult_s;
    assign w_round  = (i_cfg.shift == '0) ? '0 : (PROD_W'(1) <<< (i_cfg.shift - SHIFT_W'(1)));
    assign w_shr    = (r_prod + w_round) >>> i_cfg.shift;
    assign w_sum    = r_shr + $signed({{(PROD_W-ZP_W){1'b0}}, i_cfg.out_zp});

    always_comb begin
        if (w_sum < 0) begin
            w_q = '0;
        end else if (w_sum > $signed(ELEM_MAX)) begin
            w_q = ELEM_MAX[ELEM_W-1:0];
        end else begin
            w_q = w_sum[ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_row  <= i_cmd.row;
            r_col  <= i_cmd.col;
            r_dot  <= '0;
            r_rsum <= '0;
            r_csum <= '0;
        end else if (r_rd_vld) begin
            r_dot  <= r_dot + ACC_W'(w_ab);
            r_rsum <= r_rsum + SUM_W'(r_a_q);
            r_csum <= r_csum + SUM_W'(r_b_q);
        end
        if (r_state == S_CORR1) begin
            r_p1 <= w_p1;
            r_p2 <= w_p2;
            r_p3 <= w_p3;
        end
        if (r_state == S_CORR2) begin
            r_part <= r_dot - ACC_W'(r_p1) - ACC_W'(r_p2);
            r_p3k  <= w_p3k;
        end
        if (r_state == S_CORR3) begin
            r_acc <= r_part + ACC_W'(r_p3k);
        end
        if (r_state == S_REQ1) begin
            r_prod <= w_prod;
        end
        if (r_state == S_REQ2) begin
            r_shr <= w_shr;
        end
        if (w_load) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_acc <= r_acc;
            r_out_q   <= w_q;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.accumulator   = r_out_acc;
    assign o_out.quantized_out = r_out_q;

    `QMZP_ASSERT(a_rd_follows_read, i_clk, i_rst_n, r_rd_vld |-> $past(r_state == S_READ), "read data without a read cycle")
    `QMZP_ASSERT(a_k_in_range, i_clk, i_rst_n, (r_state == S_READ) |-> (r_k < w_k_lim), "walk index past depth")
    `QMZP_ASSERT(a_result_from_req, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_REQ3), "result loaded outside final stage")
    `QMZP_ASSERT(a_no_write_busy, i_clk, i_rst_n, (w_we_a || w_we_b) |-> (r_state == S_IDLE && !r_rd_vld), "store written during a walk")

endmodule

[bench/tb_quantized_matmul_zero_point.sv]
`timescale 1ns / 100ps
// Testbench for quantized_matmul_zero_point: loads A/B elements, requests output
// cells and checks each result against an in-bench cell predictor or a listed directed value.
// Depends on qmzp_pkg, the qmzp channel interfaces and the block's RTL.
module tb_quantized_matmul_zero_point import qmzp_pkg::*; ();

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STORE_DEPTH    = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int RANDOM_ITEMS   = 700;
    localparam int SETTLE_CYCLES  = 160;
    localparam int HOLD_AT_RESULT = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 600000;
    localparam logic [ELEM_W-1:0] ELEM_TOP = ELEM_W'((1 << ELEM_BITS) - 1);

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] val;
    } t_tb_cmd;

    typedef struct packed {
        t_tb_cmd           cmd;
        logic              typed;
        logic [ACC_W-1:0]  acc;
        logic [ELEM_W-1:0] q;
    } t_dir_row;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ACC_W-1:0]  acc;
        logic [ELEM_W-1:0] q;
    } t_cell_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qmzp_in_if  in_ch ();
    qmzp_out_if out_ch ();
    qmzp_cfg_if cfg_ch ();

    quantized_matmul_zero_point u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the block: stores, written flags and registers.
    logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic [ELEM_W-1:0] b_mem [STORE_DEPTH];
    bit                a_set [STORE_DEPTH];
    bit                b_set [STORE_DEPTH];
    t_cfg              regs;

    t_cell_result pending_cells [$];
    int fail_count   = 0;
    int useful_items = 0;
    int sent_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    bit send_quiet   = 1'b0;
    bit recv_quiet   = 1'b0;

    // Directed rows run with the reset register values: 1x1x1, zero points 0,
    // multiplier 2^30, shift 31 (roughly acc/2 rounded).
    t_dir_row directed_rows [22] = '{
        '{'{ACT_WR_A,    6'd0,  6'd0,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd0,  6'd0,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd0,  6'd0,  8'd255}, 1'b1, 32'd0,     8'd0},
        '{'{ACT_WR_A,    6'd0,  6'd0,  8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd0,  6'd0,  8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd0,  6'd0,  8'd0},   1'b1, 32'd65025, 8'd255},
        '{'{ACT_WR_A,    6'd0,  6'd0,  8'd1},   1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd0,  6'd0,  8'd1},   1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd0,  6'd0,  8'd0},   1'b1, 32'd1,     8'd1},
        '{'{ACT_COMPUTE, 6'd0,  6'd1,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd1,  6'd0,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd63, 6'd63, 8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_UNUSED,  6'd63, 6'd63, 8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_UNUSED,  6'd0,  6'd0,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_A,    6'd63, 6'd63, 8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd63, 6'd63, 8'd255}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_A,    6'd0,  6'd63, 8'd170}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd63, 6'd0,  8'd85},  1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_B,    6'd0,  6'd0,  8'd200}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd0,  6'd0,  8'd0},   1'b0, 32'd0,     8'd0},
        '{'{ACT_WR_A,    6'd0,  6'd0,  8'd128}, 1'b0, 32'd0,     8'd0},
        '{'{ACT_COMPUTE, 6'd0,  6'd0,  8'd77},  1'b0, 32'd0,     8'd0}
    };

    function automatic int dim_used(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM_DEF) begin
            return MAX_DIM_DEF;
        end
        return int'(v);
    endfunction

    function automatic int reg_width(input t_cfg_idx idx);
        case (idx)
            CFG_ROWS_M, CFG_COLS_N, CFG_DEPTH_K: return DIM_W;
            CFG_MULT:  return MULT_W;
            CFG_SHIFT: return SHIFT_W;
            default:   return ZP_W;
        endcase
    endfunction

    function automatic t_tb_cmd make_cmd(input logic [ACT_W-1:0] act, input int r, input int c,
                                         input int v);
        t_tb_cmd it;
        it.action = act;
        it.row    = IDX_W'(r);
        it.col    = IDX_W'(c);
        it.val    = ELEM_W'(v);
        return it;
    endfunction

    // Round, shift, add the output zero point and clamp in full precision.
    function automatic logic [ELEM_W-1:0] requantize_acc(input logic [ACC_W-1:0] acc);
        longint v;
        longint p;
        v = longint'(signed'(acc));
        p = v * longint'(regs.mult);
        if (regs.shift != '0) begin
            p = p + (longint'(1) << (regs.shift - 1));
        end
        p = (p >>> regs.shift) + longint'(regs.out_zp);
        if (p < 0) begin
            p = 0;
        end
        if (p > longint'(ELEM_TOP)) begin
            p = longint'(ELEM_TOP);
        end
        return ELEM_W'(p);
    endfunction

    function automatic t_cell_result predict_cell(input int m, input int n);
        t_cell_result res;
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] rsum;
        logic [ACC_W-1:0] csum;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        int klim;
        dot  = '0;
        rsum = '0;
        csum = '0;
        klim = dim_used(regs.depth_k);
        for (int k = 0; k < klim; k++) begin
            a = ACC_W'(a_mem[m * MAX_DIM_DEF + k]);
            b = ACC_W'(b_mem[k * MAX_DIM_DEF + n]);
            dot  = dot + a * b;
            rsum = rsum + a;
            csum = csum + b;
        end
        res.row = IDX_W'(m);
        res.col = IDX_W'(n);
        res.acc = dot - ACC_W'(regs.zp_b) * rsum - ACC_W'(regs.zp_a) * csum
                + ACC_W'(regs.zp_a) * ACC_W'(regs.zp_b) * ACC_W'(klim);
        res.q   = requantize_acc(res.acc);
        return res;
    endfunction

    // Update the shadow for one accepted transaction and queue its result.
    task automatic apply_item(input t_tb_cmd it, input logic typed,
                              input logic [ACC_W-1:0] t_acc, input logic [ELEM_W-1:0] t_q);
        t_cell_result res;
        case (it.action)
            ACT_WR_A: begin
                a_mem[it.row * MAX_DIM_DEF + it.col] = it.val;
                a_set[it.row * MAX_DIM_DEF + it.col] = 1'b1;
                useful_items++;
            end
            ACT_WR_B: begin
                b_mem[it.row * MAX_DIM_DEF + it.col] = it.val;
                b_set[it.row * MAX_DIM_DEF + it.col] = 1'b1;
                useful_items++;
            end
            ACT_COMPUTE: begin
                if (int'(it.row) < dim_used(regs.rows_m)
                    && int'(it.col) < dim_used(regs.cols_n)) begin
                    res = predict_cell(int'(it.row), int'(it.col));
                    if (typed) begin
                        res.acc = t_acc;
                        res.q   = t_q;
                    end
                    pending_cells.insert(pending_cells.size(), res);
                    useful_items++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input t_tb_cmd it, input logic typed,
                             input logic [ACC_W-1:0] t_acc, input logic [ELEM_W-1:0] t_q);
        int gap;
        if (sent_count % 40 == 0) begin
            send_quiet = ($urandom_range(0, 3) == 0);
        end
        gap = send_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= it.action;
        in_ch.row_index  <= it.row;
        in_ch.col_index  <= it.col;
        in_ch.elem_value <= it.val;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
        apply_item(it, typed, t_acc, t_q);
    endtask

    // Write every element the cell will read that has not been written yet.
    task automatic load_cell(input int m, input int n);
        int klim;
        klim = dim_used(regs.depth_k);
        for (int k = 0; k < klim; k++) begin
            if (!a_set[m * MAX_DIM_DEF + k]) begin
                send_item(make_cmd(ACT_WR_A, m, k, $urandom_range(0, 255)), 1'b0, '0, '0);
            end
            if (!b_set[k * MAX_DIM_DEF + n]) begin
                send_item(make_cmd(ACT_WR_B, k, n, $urandom_range(0, 255)), 1'b0, '0, '0);
            end
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = value;
        // Set unused upper bits now and then; the register must keep its width.
        if ($urandom_range(0, 3) == 0) begin
            data = data | (CFG_DATA_W'($urandom) << reg_width(idx));
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_ROWS_M:  regs.rows_m  = data[DIM_W-1:0];
            CFG_COLS_N:  regs.cols_n  = data[DIM_W-1:0];
            CFG_DEPTH_K: regs.depth_k = data[DIM_W-1:0];
            CFG_ZP_A:    regs.zp_a    = data[ZP_W-1:0];
            CFG_ZP_B:    regs.zp_b    = data[ZP_W-1:0];
            CFG_MULT:    regs.mult    = data[MULT_W-1:0];
            CFG_SHIFT:   regs.shift   = data[SHIFT_W-1:0];
            default:     regs.out_zp  = data[ZP_W-1:0];
        endcase
    endtask

    task automatic configure(input int rows, input int cols, input int depth, input int zpa,
                             input int zpb, input logic [MULT_W-1:0] mult, input int shift,
                             input int ozp);
        write_reg(CFG_ROWS_M, CFG_DATA_W'(rows));
        write_reg(CFG_COLS_N, CFG_DATA_W'(cols));
        write_reg(CFG_DEPTH_K, CFG_DATA_W'(depth));
        write_reg(CFG_ZP_A, CFG_DATA_W'(zpa));
        write_reg(CFG_ZP_B, CFG_DATA_W'(zpb));
        write_reg(CFG_MULT, CFG_DATA_W'(mult));
        write_reg(CFG_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_OUT_ZP, CFG_DATA_W'(ozp));
        cfg_ch.valid <= 1'b0;
    endtask

    // Extreme settings first, then small random matrices.
    task automatic pick_config(input int phase);
        int shift;
        case (phase)
            0: configure(0, 0, 0, 255, 255, 31'h7FFF_FFFF, 0, 255);
            1: configure(64, 64, 2, 0, 255, 31'd0, 63, 0);
            2: configure(1, 1, 127, 128, 3, 31'h4000_0000, 40, 128);
            3: configure(127, 65, 5, 255, 0, 31'h7FFF_FFFF, 38, 0);
            default: begin
                shift = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(20, 50);
                configure($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 8),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          MULT_W'($urandom), shift, $urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic run_phase(input int budget);
        int start;
        int r;
        int m;
        int n;
        start = useful_items;
        while (useful_items - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m = $urandom_range(0, dim_used(regs.rows_m) - 1);
                n = $urandom_range(0, dim_used(regs.cols_n) - 1);
                load_cell(m, n);
                send_item(make_cmd(ACT_COMPUTE, m, n, $urandom_range(0, 255)), 1'b0, '0, '0);
            end else if (r < 67) begin
                // Any cell; ones outside the output are dropped by the block.
                m = $urandom_range(0, 63);
                n = $urandom_range(0, 63);
                if (m < dim_used(regs.rows_m) && n < dim_used(regs.cols_n)) begin
                    load_cell(m, n);
                end
                send_item(make_cmd(ACT_COMPUTE, m, n, $urandom_range(0, 255)), 1'b0, '0, '0);
            end else if (r < 92) begin
                send_item(make_cmd($urandom_range(0, 1) ? ACT_WR_B : ACT_WR_A,
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 255)), 1'b0, '0, '0);
            end else begin
                send_item(make_cmd(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 255)), 1'b0, '0, '0);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off to back up the queue.
    initial begin
        int stall;
        t_cell_result exp_cell;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (results_seen % 16 == 0) begin
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 3);
            if (results_seen == HOLD_AT_RESULT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            results_seen++;
            if (pending_cells.size() == 0) begin
                $error("unexpected result for cell (%0d,%0d)", out_ch.out_row, out_ch.out_col);
                fail_count++;
            end else begin
                exp_cell = pending_cells.pop_front();
                if (out_ch.out_row !== exp_cell.row) begin
                    $error("out_row: expected %0d, got %0d", exp_cell.row, out_ch.out_row);
                    fail_count++;
                end
                if (out_ch.out_col !== exp_cell.col) begin
                    $error("out_col: expected %0d, got %0d", exp_cell.col, out_ch.out_col);
                    fail_count++;
                end
                if (out_ch.accumulator !== exp_cell.acc) begin
                    $error("accumulator: expected %0d, got %0d",
                           $signed(exp_cell.acc), out_ch.accumulator);
                    fail_count++;
                end
                if (out_ch.quantized_out !== exp_cell.q) begin
                    $error("quantized_out: expected %0d, got %0d",
                           exp_cell.q, out_ch.quantized_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int random_start;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_WR_A;
        in_ch.row_index  = '0;
        in_ch.col_index  = '0;
        in_ch.elem_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_ROWS_M;
        cfg_ch.data      = '0;
        regs.rows_m  = DIM_W'(1);
        regs.cols_n  = DIM_W'(1);
        regs.depth_k = DIM_W'(1);
        regs.zp_a    = '0;
        regs.zp_b    = '0;
        regs.mult    = MULT_W'(32'h4000_0000);
        regs.shift   = SHIFT_W'(31);
        regs.out_zp  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].typed,
                      directed_rows[i].acc, directed_rows[i].q);
        end

        random_start = useful_items;
        phase = 0;
        while (useful_items - random_start < RANDOM_ITEMS) begin
            drain();
            pick_config(phase);
            run_phase(phase < 4 ? 40 : 60);
            phase++;
        end
        drain();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/qmzp_pkg.sv
rtl/core/qmzp_if.sv
rtl/core/qmzp_front.sv
rtl/core/qmzp_queue.sv
rtl/core/qmzp_back.sv
rtl/core/quantized_matmul_zero_point.sv
bench/tb_quantized_matmul_zero_point.sv
